// ===== sv/rsi_pkg.sv =====
// Shared widths, constants and controller/datapath types of the relative strength index block.
package rsi_pkg;

    // Width of the price field on the input channel.
    localparam int PRICE_PORT_BITS = 32;
    // Width of the window length register and of the serial divisor.
    localparam int LEN_BITS = 10;
    // Width of the result in hundredths; also the number of ratio digits.
    localparam int RSI_BITS = 14;
    // Widest fixed point average that the block keeps.
    localparam int AVG_CAP = 62;

    localparam logic [LEN_BITS-1:0] RESET_LENGTH     = 10'd14;
    localparam logic [RSI_BITS-1:0] SCALE_HUNDREDTHS = 14'd10000;

    typedef enum logic [1:0] {
        RES_ZERO,
        RES_FULL,
        RES_RATIO
    } res_sel_t;

    typedef struct packed {
        logic     in_ready;
        logic     clear_series;
        logic     take_change;
        logic     accumulate;
        logic     load_wilder;
        logic     load_first;
        logic     finish;
        logic     ratio_start;
        logic     out_load;
        res_sel_t res_sel;
    } rsi_cmd_t;

    typedef struct packed {
        logic in_valid;
        logic first;
        logic count_below;
        logic count_reaches;
        logic div_done;
        logic loss_zero;
        logic ratio_done;
        logic out_free;
    } rsi_status_t;

endpackage

// ===== sv/rsi_in_if.sv =====
// Input channel carrying one close price word per handshake.
interface rsi_in_if import rsi_pkg::*; ();
    logic                       valid;
    logic                       ready;
    logic [PRICE_PORT_BITS-1:0] price;
    logic                       series_start;

    modport source (output valid, output price, output series_start, input ready);
    modport sink   (input valid, input price, input series_start, output ready);
endinterface

// ===== sv/rsi_out_if.sv =====
// Output channel carrying one RSI result word per handshake.
interface rsi_out_if import rsi_pkg::*; ();
    logic                valid;
    logic                ready;
    logic [RSI_BITS-1:0] rsi_hundredths;
    logic                rsi_valid;

    modport source (output valid, output rsi_hundredths, output rsi_valid, input ready);
    modport sink   (input valid, input rsi_hundredths, input rsi_valid, output ready);
endinterface

// ===== sv/rsi_div.sv =====
// Serial restoring divider by the window length, one quotient bit per cycle.
module rsi_div import rsi_pkg::*; #(
    parameter int N_BITS = 48
) (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                start,
    input  logic [LEN_BITS-1:0] divisor,
    input  logic [N_BITS-1:0]   dividend,
    input  logic [LEN_BITS-1:0] rem_init,
    output logic                busy,
    output logic [N_BITS-1:0]   quotient,
    output logic [LEN_BITS-1:0] remainder
);

    localparam int CNT_BITS = $clog2(N_BITS + 1);

    logic                busy_reg;
    logic [CNT_BITS-1:0] count_reg;
    logic [N_BITS-1:0]   shift_reg;
    logic [LEN_BITS-1:0] rem_reg;
    logic [LEN_BITS-1:0] divisor_reg;

    logic [LEN_BITS:0]   trial;
    logic [LEN_BITS:0]   trial_diff;
    logic                trial_ge;

    // The dividend shifts out at the top while quotient bits enter at the bottom.
    assign trial      = {rem_reg, shift_reg[N_BITS-1]};
    assign trial_ge   = trial >= {1'b0, divisor_reg};
    assign trial_diff = trial - {1'b0, divisor_reg};

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg  <= 1'b0;
            count_reg <= '0;
        end
        else if (start)
        begin
            busy_reg  <= 1'b1;
            count_reg <= CNT_BITS'(N_BITS);
        end
        else if (busy_reg)
        begin
            count_reg <= count_reg - CNT_BITS'(1);
            if (count_reg == CNT_BITS'(1))
            begin
                busy_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (start)
        begin
            shift_reg   <= dividend;
            rem_reg     <= rem_init;
            divisor_reg <= divisor;
        end
        else if (busy_reg)
        begin
            shift_reg <= {shift_reg[N_BITS-2:0], trial_ge};
            rem_reg   <= trial_ge ? trial_diff[LEN_BITS-1:0] : trial[LEN_BITS-1:0];
        end
    end

    assign busy      = busy_reg;
    assign quotient  = shift_reg;
    assign remainder = rem_reg;

endmodule

// ===== sv/rsi_ratio.sv =====
// Serial unit forming floor(10000 * g / (g + l)) one decimal-scale bit at a time.
module rsi_ratio import rsi_pkg::*; #(
    parameter int AVG_BITS = 48
) (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                start,
    input  logic [AVG_BITS-1:0] gain,
    input  logic [AVG_BITS-1:0] loss,
    output logic                busy,
    output logic [RSI_BITS-1:0] ratio
);

    localparam int BIT_BITS = $clog2(RSI_BITS);

    logic                busy_reg;
    logic                phase_reg;
    logic [BIT_BITS-1:0] bit_reg;
    logic [AVG_BITS-1:0] g_reg;
    logic [AVG_BITS:0]   d_reg;
    logic [AVG_BITS+1:0] r_reg;
    logic [RSI_BITS-1:0] q_reg;

    logic [AVG_BITS+1:0] d_wide;
    logic [AVG_BITS+1:0] r_doubled;
    logic [AVG_BITS+1:0] r_added;
    logic                ge_doubled;
    logic                ge_added;
    logic                last_bit;

    assign d_wide     = {1'b0, d_reg};
    assign r_doubled  = {r_reg[AVG_BITS:0], 1'b0};
    assign r_added    = r_reg + {2'b00, g_reg};
    assign ge_doubled = r_doubled >= d_wide;
    assign ge_added   = r_added >= d_wide;
    assign last_bit   = bit_reg == '0;

    // Phase zero doubles the partial remainder; phase one adds the gain where the
    // scale constant has a one and is skipped elsewhere.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg  <= 1'b0;
            phase_reg <= 1'b0;
            bit_reg   <= '0;
        end
        else if (start)
        begin
            busy_reg  <= 1'b1;
            phase_reg <= 1'b0;
            bit_reg   <= BIT_BITS'(RSI_BITS - 1);
        end
        else if (busy_reg)
        begin
            if (!phase_reg && SCALE_HUNDREDTHS[bit_reg])
            begin
                phase_reg <= 1'b1;
            end
            else
            begin
                phase_reg <= 1'b0;
                if (last_bit)
                begin
                    busy_reg <= 1'b0;
                end
                else
                begin
                    bit_reg <= bit_reg - BIT_BITS'(1);
                end
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (start)
        begin
            g_reg <= gain;
            d_reg <= {1'b0, gain} + {1'b0, loss};
            r_reg <= '0;
            q_reg <= '0;
        end
        else if (busy_reg)
        begin
            if (!phase_reg)
            begin
                r_reg <= ge_doubled ? r_doubled - d_wide : r_doubled;
                q_reg <= {q_reg[RSI_BITS-2:0], ge_doubled};
            end
            else
            begin
                r_reg <= ge_added ? r_added - d_wide : r_added;
                q_reg <= q_reg + RSI_BITS'(ge_added);
            end
        end
    end

    assign busy  = busy_reg;
    assign ratio = q_reg;

`ifndef SYNTH
    a_ratio_in_range: assert property (@(posedge clk) disable iff (!rst_n)
        $fell(busy_reg) |-> q_reg <= SCALE_HUNDREDTHS)
        else $error("ratio above full scale");

    a_remainder_bound: assert property (@(posedge clk) disable iff (!rst_n)
        $fell(busy_reg) |-> r_reg < d_wide)
        else $error("ratio remainder not below divisor");
`endif

endmodule

// ===== sv/rsi_dp.sv =====
// Datapath: series state, two averaging lanes with serial dividers, ratio unit, output register.
module rsi_dp import rsi_pkg::*; #(
    parameter int PRICE_BITS = 32,
    parameter int FRAC_BITS  = 16,
    parameter int AVG_BITS   = 48
) (
    input  logic                       clk,
    input  logic                       rst_n,
    input  logic                       cfg_we,
    input  logic [LEN_BITS-1:0]        cfg_wdata,
    input  logic                       in_valid,
    input  logic [PRICE_PORT_BITS-1:0] in_price,
    input  logic                       in_start,
    input  logic                       out_ready,
    input  rsi_cmd_t                   cmd,
    output rsi_status_t                st,
    output logic                       out_valid,
    output logic [RSI_BITS-1:0]        out_rsi,
    output logic                       out_flag
);

    // Sums of up to the longest window of changes, on top of a full average.
    localparam int SUM_BITS   = ((AVG_BITS > PRICE_BITS + LEN_BITS) ?
                                 AVG_BITS : PRICE_BITS + LEN_BITS) + 1;
    localparam int SHIFT_BITS = AVG_BITS - FRAC_BITS;
    localparam int CMP_BITS   = SUM_BITS + 2;
    localparam int WIDE_BITS  = PRICE_BITS + FRAC_BITS;
    localparam logic [AVG_BITS-1:0] AVG_MAX = '1;

    logic [LEN_BITS-1:0]   len_reg;
    logic [LEN_BITS-1:0]   eff_len;
    logic [PRICE_BITS-1:0] price_reg;
    logic                  start_reg;
    logic [PRICE_BITS-1:0] prev_reg;
    logic                  taken_reg;
    logic [LEN_BITS-1:0]   count_reg;
    logic [SUM_BITS-1:0]   sum_reg [2];
    logic [PRICE_BITS-1:0] change_reg [2];
    logic                  sub_reg [2];
    logic                  sat_reg [2];
    logic                  first_mode_reg;
    logic                  out_valid_reg;
    logic [RSI_BITS-1:0]   out_rsi_reg;
    logic                  out_flag_reg;

    logic [AVG_BITS-1:0]   avg_now [2];
    logic [WIDE_BITS-1:0]  fixed_wide [2];
    logic [AVG_BITS-1:0]   fixed_change [2];
    logic                  change_up [2];
    logic [AVG_BITS-1:0]   wilder_diff [2];
    logic [SUM_BITS+FRAC_BITS-1:0] sum_scaled [2];
    logic                  first_sat [2];
    logic [CMP_BITS-1:0]   sat_limit;
    logic [AVG_BITS-1:0]   div_dividend [2];
    logic [LEN_BITS-1:0]   div_rem_init [2];
    logic                  div_busy [2];
    logic [AVG_BITS-1:0]   div_quot [2];
    logic [LEN_BITS-1:0]   div_rem [2];
    logic [AVG_BITS-1:0]   avg_result [2];
    logic                  ratio_busy;
    logic [RSI_BITS-1:0]   ratio_q;
    logic                  in_accept;
    logic                  div_start;

    assign eff_len   = (len_reg == '0) ? LEN_BITS'(1) : len_reg;
    assign in_accept = in_valid && cmd.in_ready;
    assign div_start = cmd.load_first || cmd.load_wilder;
    assign sat_limit = CMP_BITS'(eff_len) << SHIFT_BITS;

    always_comb
    begin
        for (int i = 0; i < 2; i++)
        begin
            avg_now[i]      = sum_reg[i][AVG_BITS-1:0];
            // Change moved into fixed point, saturating at the top of the average range.
            fixed_wide[i]   = {change_reg[i], {FRAC_BITS{1'b0}}};
            fixed_change[i] = ((fixed_wide[i] >> AVG_BITS) != '0) ?
                              AVG_MAX : fixed_wide[i][AVG_BITS-1:0];
            change_up[i]    = fixed_change[i] >= avg_now[i];
            wilder_diff[i]  = change_up[i] ? fixed_change[i] - avg_now[i]
                                           : avg_now[i] - fixed_change[i];
            // First average: (sum << FRAC_BITS) / len. The high part of the dividend
            // already sits below len unless the quotient saturates.
            sum_scaled[i]   = {sum_reg[i], {FRAC_BITS{1'b0}}};
            first_sat[i]    = CMP_BITS'(sum_reg[i]) >= sat_limit;
            div_dividend[i] = cmd.load_first ? sum_scaled[i][AVG_BITS-1:0] : wilder_diff[i];
            div_rem_init[i] = cmd.load_first ? LEN_BITS'(sum_scaled[i] >> AVG_BITS) : '0;
            if (first_mode_reg)
            begin
                avg_result[i] = sat_reg[i] ? AVG_MAX : div_quot[i];
            end
            else if (sub_reg[i])
            begin
                // Falling towards the change: round the step up.
                avg_result[i] = avg_now[i] - div_quot[i] - AVG_BITS'(div_rem[i] != '0);
            end
            else
            begin
                avg_result[i] = avg_now[i] + div_quot[i];
            end
        end
    end

    for (genvar i = 0; i < 2; i++)
    begin : g_lane
        rsi_div #(
            .N_BITS (AVG_BITS)
        ) u_div (
            .clk       (clk),
            .rst_n     (rst_n),
            .start     (div_start),
            .divisor   (eff_len),
            .dividend  (div_dividend[i]),
            .rem_init  (div_rem_init[i]),
            .busy      (div_busy[i]),
            .quotient  (div_quot[i]),
            .remainder (div_rem[i])
        );
    end

    rsi_ratio #(
        .AVG_BITS (AVG_BITS)
    ) u_ratio (
        .clk   (clk),
        .rst_n (rst_n),
        .start (cmd.ratio_start),
        .gain  (avg_now[0]),
        .loss  (avg_now[1]),
        .busy  (ratio_busy),
        .ratio (ratio_q)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            len_reg       <= RESET_LENGTH;
            prev_reg      <= '0;
            taken_reg     <= 1'b0;
            count_reg     <= '0;
            sum_reg[0]    <= '0;
            sum_reg[1]    <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (cfg_we)
            begin
                len_reg <= cfg_wdata;
            end
            if (cmd.clear_series)
            begin
                prev_reg   <= price_reg;
                taken_reg  <= 1'b1;
                count_reg  <= '0;
                sum_reg[0] <= '0;
                sum_reg[1] <= '0;
            end
            if (cmd.take_change)
            begin
                prev_reg <= price_reg;
            end
            for (int i = 0; i < 2; i++)
            begin
                if (cmd.accumulate)
                begin
                    sum_reg[i] <= sum_reg[i] + SUM_BITS'(change_reg[i]);
                end
                else if (cmd.load_wilder)
                begin
                    sum_reg[i] <= SUM_BITS'(avg_now[i]);
                end
                else if (cmd.finish)
                begin
                    sum_reg[i] <= SUM_BITS'(avg_result[i]);
                end
            end
            if (cmd.accumulate)
            begin
                count_reg <= count_reg + LEN_BITS'(1);
            end
            else if (cmd.load_wilder)
            begin
                count_reg <= eff_len;
            end
            if (cmd.out_load)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (out_ready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_accept)
        begin
            price_reg <= PRICE_BITS'(in_price);
            start_reg <= in_start;
        end
        if (cmd.take_change)
        begin
            change_reg[0] <= (price_reg > prev_reg) ? price_reg - prev_reg : '0;
            change_reg[1] <= (price_reg > prev_reg) ? '0 : prev_reg - price_reg;
        end
        if (div_start)
        begin
            first_mode_reg <= cmd.load_first;
        end
        for (int i = 0; i < 2; i++)
        begin
            if (cmd.load_first)
            begin
                sat_reg[i] <= first_sat[i];
            end
            if (cmd.load_wilder)
            begin
                sub_reg[i] <= !change_up[i];
            end
        end
        if (cmd.out_load)
        begin
            unique case (cmd.res_sel)
                RES_ZERO:
                begin
                    out_rsi_reg  <= '0;
                    out_flag_reg <= 1'b0;
                end
                RES_FULL:
                begin
                    out_rsi_reg  <= SCALE_HUNDREDTHS;
                    out_flag_reg <= 1'b1;
                end
                RES_RATIO:
                begin
                    out_rsi_reg  <= ratio_q;
                    out_flag_reg <= 1'b1;
                end
                default:
                begin
                    out_rsi_reg  <= '0;
                    out_flag_reg <= 1'b0;
                end
            endcase
        end
    end

    assign st.in_valid      = in_valid;
    assign st.first         = start_reg || !taken_reg;
    assign st.count_below   = count_reg < eff_len;
    assign st.count_reaches = ({1'b0, count_reg} + (LEN_BITS + 1)'(1)) >= {1'b0, eff_len};
    assign st.div_done      = !div_busy[0] && !div_busy[1];
    assign st.loss_zero     = sum_reg[1] == '0;
    assign st.ratio_done    = !ratio_busy;
    assign st.out_free      = !out_valid_reg || out_ready;

    assign out_valid = out_valid_reg;
    assign out_rsi   = out_rsi_reg;
    assign out_flag  = out_flag_reg;

`ifndef SYNTH
    a_average_in_range: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.finish |=> ((sum_reg[0] >> AVG_BITS) == '0) && ((sum_reg[1] >> AVG_BITS) == '0))
        else $error("average left the fixed point range");
`endif

endmodule

// ===== sv/rsi_ctrl.sv =====
// Controller state machine sequencing one price word through the datapath.
module rsi_ctrl import rsi_pkg::*; (
    input  logic        clk,
    input  logic        rst_n,
    input  rsi_status_t st,
    output rsi_cmd_t    cmd
);

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_EVAL,
        ST_UPDATE,
        ST_PREP,
        ST_DIV,
        ST_RSTART,
        ST_RATIO,
        ST_PUBLISH
    } state_t;

    state_t   state_reg;
    state_t   state_next;
    res_sel_t res_sel_reg;
    res_sel_t res_sel_next;

    always_comb
    begin
        cmd          = '0;
        cmd.res_sel  = res_sel_reg;
        state_next   = state_reg;
        res_sel_next = res_sel_reg;
        unique case (state_reg)
            ST_IDLE:
            begin
                cmd.in_ready = 1'b1;
                if (st.in_valid)
                begin
                    state_next = ST_EVAL;
                end
            end
            ST_EVAL:
            begin
                if (st.first)
                begin
                    cmd.clear_series = 1'b1;
                    res_sel_next     = RES_ZERO;
                    state_next       = ST_PUBLISH;
                end
                else
                begin
                    cmd.take_change = 1'b1;
                    state_next      = ST_UPDATE;
                end
            end
            ST_UPDATE:
            begin
                if (st.count_below)
                begin
                    cmd.accumulate = 1'b1;
                    if (st.count_reaches)
                    begin
                        state_next = ST_PREP;
                    end
                    else
                    begin
                        res_sel_next = RES_ZERO;
                        state_next   = ST_PUBLISH;
                    end
                end
                else
                begin
                    cmd.load_wilder = 1'b1;
                    state_next      = ST_DIV;
                end
            end
            ST_PREP:
            begin
                cmd.load_first = 1'b1;
                state_next     = ST_DIV;
            end
            ST_DIV:
            begin
                if (st.div_done)
                begin
                    cmd.finish = 1'b1;
                    state_next = ST_RSTART;
                end
            end
            ST_RSTART:
            begin
                if (st.loss_zero)
                begin
                    res_sel_next = RES_FULL;
                    state_next   = ST_PUBLISH;
                end
                else
                begin
                    cmd.ratio_start = 1'b1;
                    state_next      = ST_RATIO;
                end
            end
            ST_RATIO:
            begin
                if (st.ratio_done)
                begin
                    res_sel_next = RES_RATIO;
                    state_next   = ST_PUBLISH;
                end
            end
            ST_PUBLISH:
            begin
                if (st.out_free)
                begin
                    cmd.out_load = 1'b1;
                    state_next   = ST_IDLE;
                end
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg   <= ST_IDLE;
            res_sel_reg <= RES_ZERO;
        end
        else
        begin
            state_reg   <= state_next;
            res_sel_reg <= res_sel_next;
        end
    end

`ifndef SYNTH
    a_units_quiet_when_idle: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_IDLE) |-> (st.div_done && st.ratio_done))
        else $error("arithmetic unit still running while accepting words");
`endif

endmodule

// ===== sv/relative_strength_index.sv =====
// Top level of the Wilder relative strength index block.
//
// The block takes one close price word at a time and returns one result word for
// each, in order: the RSI in hundredths (0 to 10000) and a flag that is set once
// window_length price changes have been seen in the current series. A word with
// series_start set, or the first word after reset, opens a new series and returns
// zero with the flag clear; so does every word while the first window is still
// being summed. The first averages are the raw sums of gains and losses divided by
// the window length, after which each change updates them by Wilder smoothing,
// all in unsigned fixed point with FRAC_BITS fraction bits and every division
// truncated. A zero loss average gives 10000. Only the low PRICE_BITS bits of the
// price are used, and a window length of zero acts as one. The block works on one
// word at a time. AVG_BITS is PRICE_BITS + FRAC_BITS, capped at 62. The word that
// forms the first averages and every word that smooths them pass through the two
// serial dividers, which produce one quotient bit per cycle and hold the controller
// until both are done, and then through the ratio unit, which works through the 14
// result bits one at a time and hands the ratio over; with a zero loss average the
// ratio unit is skipped. The next word is accepted in the cycle after the result is
// loaded. A result that the consumer has not yet taken waits in the output register
// while the next price word is accepted, and holds the block back only if the
// following result is ready before it is taken. The window length register is
// written through cfg_we and cfg_wdata; the user must write it only while no word
// is in flight, as the block itself does not enforce this.
module relative_strength_index import rsi_pkg::*; #(
    parameter int PRICE_BITS = 32,
    parameter int FRAC_BITS  = 16
) (
    input  logic                clk,
    input  logic                rst_n,
    rsi_in_if.sink              prices,
    rsi_out_if.source           results,
    input  logic                cfg_we,
    input  logic [LEN_BITS-1:0] cfg_wdata
);

    // Width of the fixed point averages; they are capped at 62 bits.
    localparam int AVG_BITS = (PRICE_BITS + FRAC_BITS > AVG_CAP) ?
                              AVG_CAP : PRICE_BITS + FRAC_BITS;

    rsi_cmd_t    cmd;
    rsi_status_t st;

    // The controller only steps through the sequence; every register that holds a
    // value of the series lives in the datapath.
    rsi_ctrl u_ctrl (
        .clk   (clk),
        .rst_n (rst_n),
        .st    (st),
        .cmd   (cmd)
    );

    rsi_dp #(
        .PRICE_BITS (PRICE_BITS),
        .FRAC_BITS  (FRAC_BITS),
        .AVG_BITS   (AVG_BITS)
    ) u_dp (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_wdata (cfg_wdata),
        .in_valid  (prices.valid),
        .in_price  (prices.price),
        .in_start  (prices.series_start),
        .out_ready (results.ready),
        .cmd       (cmd),
        .st        (st),
        .out_valid (results.valid),
        .out_rsi   (results.rsi_hundredths),
        .out_flag  (results.rsi_valid)
    );

    // A new price word is taken only when the controller is waiting for one.
    assign prices.ready = cmd.in_ready;

endmodule
